[sv/cell_window_fault_detector_macros.svh]
// Assertion helpers used by the detector's accumulator module.
// Every check is sampled on clk and held off while rst_n is low.
`ifndef CELL_WINDOW_FAULT_DETECTOR_MACROS_SVH
`define CELL_WINDOW_FAULT_DETECTOR_MACROS_SVH

// Same-cycle implication
`define CWFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwfd check failed");

// Next-cycle implication
`define CWFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwfd check failed");

`endif

[sv/cwfd_pkg.sv]
package cwfd_pkg;

  // Location records kept per scan
  localparam int RECORD_SLOTS = 3;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_UNDER_LIMIT = 1'b0;
  localparam logic REG_OVER_LIMIT  = 1'b1;

  // Fault hit codes, also the fault mask bits
  localparam logic [1:0] HIT_NONE  = 2'b00;
  localparam logic [1:0] HIT_UNDER = 2'b01;
  localparam logic [1:0] HIT_OVER  = 2'b10;

  // Fault count saturation value
  localparam logic [7:0] TALLY_MAX = 8'hFF;

  // Stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [15:0] under_limit;
    logic [15:0] over_limit;
  } cwfd_limits_t;

  // One compared sample handed to the accumulator
  typedef struct packed {
    logic       last;
    logic [1:0] hit;
    logic [7:0] location;
  } cwfd_sample_t;

  // Scan summary
  typedef struct packed {
    logic [7:0] fault_total;
    logic [7:0] third_location;
    logic [7:0] second_location;
    logic [7:0] first_location;
    logic [1:0] fault_mask;
    logic       any_fault;
  } cwfd_result_t;

endpackage

[sv/cwfd_cfg_regs.sv]
module cwfd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cwfd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cwfd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cwfd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output cwfd_pkg::cwfd_limits_t          limits
);

  logic [15:0] under_limit_r;
  logic [15:0] over_limit_r;
  logic        wr_en;
  logic        reg_sel;
  logic [15:0] rd_val;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      under_limit_r <= 16'h0000;
      over_limit_r  <= 16'hFFFF;
    end else if (wr_en) begin
      case (reg_sel)
        cwfd_pkg::REG_UNDER_LIMIT: under_limit_r <= cfg_pwdata[15:0];
        cwfd_pkg::REG_OVER_LIMIT:  over_limit_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      cwfd_pkg::REG_UNDER_LIMIT: rd_val = under_limit_r;
      cwfd_pkg::REG_OVER_LIMIT:  rd_val = over_limit_r;
      default:                   rd_val = 16'h0000;
    endcase
  end

  assign cfg_prdata = {{(cwfd_pkg::CFG_DATA_W-16){1'b0}}, rd_val};

  assign limits.under_limit = under_limit_r;
  assign limits.over_limit  = over_limit_r;

endmodule

[sv/cwfd_window_cmp.sv]
module cwfd_window_cmp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             monitor_index,
  input  logic [4:0]             cell_index,
  input  logic [15:0]            cell_code,
  input  logic                   scan_end,
  input  cwfd_pkg::cwfd_limits_t limits,
  input  logic                   advance,
  output logic                   sample_valid,
  output cwfd_pkg::cwfd_sample_t sample
);

  logic        valid_r;
  logic [3:0]  monitor_r;
  logic [4:0]  cell_r;
  logic [15:0] code_r;
  logic        last_r;

  // Register takes a new transfer when empty or when its item moves on
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      monitor_r <= monitor_index;
      cell_r    <= cell_index;
      code_r    <= cell_code;
      last_r    <= scan_end;
    end
  end

  // Window compare: undervoltage is tested first and wins
  always_comb begin
    if (code_r < limits.under_limit) begin
      sample.hit = cwfd_pkg::HIT_UNDER;
    end else if (code_r > limits.over_limit) begin
      sample.hit = cwfd_pkg::HIT_OVER;
    end else begin
      sample.hit = cwfd_pkg::HIT_NONE;
    end
  end

  // Location byte: monitor nibble high, low four bits of the cell index low
  assign sample.location = {monitor_r, cell_r[3:0]};
  assign sample.last     = last_r;
  assign sample_valid    = valid_r;

endmodule

[sv/cwfd_accum.sv]
`include "cell_window_fault_detector_macros.svh"

module cwfd_accum #(
  parameter int RECORD_SLOTS = cwfd_pkg::RECORD_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   sample_valid,
  input  cwfd_pkg::cwfd_sample_t sample,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cwfd_pkg::cwfd_result_t result
);

  logic [1:0]             mask_r;
  logic [7:0]             tally_r;
  logic [7:0]             rec_r   [RECORD_SLOTS];
  logic [1:0]             mask_nxt;
  logic [7:0]             tally_nxt;
  logic [7:0]             rec_nxt [RECORD_SLOTS];
  logic                   is_fault;
  logic                   out_valid_r;
  cwfd_pkg::cwfd_result_t result_r;

  // A non-final sample always folds in; a final one needs the result register
  assign advance = sample_valid && (!sample.last || !out_valid_r || out_ready);

  assign is_fault = (sample.hit != cwfd_pkg::HIT_NONE);

  // Next scan state with this sample included
  always_comb begin
    mask_nxt  = mask_r | sample.hit;
    tally_nxt = (is_fault && (tally_r != cwfd_pkg::TALLY_MAX)) ? tally_r + 8'd1 : tally_r;
    for (int k = 0; k < RECORD_SLOTS; k++) begin
      rec_nxt[k] = (is_fault && (tally_r == 8'(k))) ? sample.location : rec_r[k];
    end
  end

  // Scan state, cleared after each summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= cwfd_pkg::HIT_NONE;
      tally_r <= 8'd0;
      for (int k = 0; k < RECORD_SLOTS; k++) begin
        rec_r[k] <= 8'd0;
      end
    end else if (advance) begin
      if (sample.last) begin
        mask_r  <= cwfd_pkg::HIT_NONE;
        tally_r <= 8'd0;
        for (int k = 0; k < RECORD_SLOTS; k++) begin
          rec_r[k] <= 8'd0;
        end
      end else begin
        mask_r  <= mask_nxt;
        tally_r <= tally_nxt;
        for (int k = 0; k < RECORD_SLOTS; k++) begin
          rec_r[k] <= rec_nxt[k];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && sample.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sample.last) begin
      result_r.any_fault       <= (mask_nxt != cwfd_pkg::HIT_NONE);
      result_r.fault_mask      <= mask_nxt;
      result_r.first_location  <= rec_nxt[0];
      result_r.second_location <= rec_nxt[1];
      result_r.third_location  <= rec_nxt[2];
      result_r.fault_total     <= tally_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Checks
  `CWFD_ASSERT_IMPL(a_flag_matches_mask, out_valid_r,
    result_r.any_fault == (result_r.fault_mask != cwfd_pkg::HIT_NONE))
  `CWFD_ASSERT_NEXT(a_clear_after_scan, advance && sample.last,
    (tally_r == 8'd0) && (mask_r == cwfd_pkg::HIT_NONE))
  `CWFD_ASSERT_NEXT(a_result_follows_last, advance && sample.last, out_valid_r)
  `CWFD_ASSERT_IMPL(a_no_mask_without_count, tally_r == 8'd0, mask_r == cwfd_pkg::HIT_NONE)
  `CWFD_ASSERT_IMPL(a_unused_slot_zero, tally_r < 8'(RECORD_SLOTS),
    rec_r[RECORD_SLOTS-1] == 8'd0)

endmodule

[sv/cell_window_fault_detector.sv]
// Cell window fault detector.
// Input stream: one cell sample per transfer; in_tlast marks the last cell
// of a scan. Each code is checked against the undervoltage limit first, then
// the overvoltage limit; faults are counted (saturating at 255), flagged in a
// two-bit mask, and the first three fault locations are kept.
// Output stream: one summary transfer per scan, issued for the in_tlast item.
// Path: a final sample passes the input register, then the result register,
// before its summary is on out_tvalid.
// Throughput: one sample per cycle (barring the stall below), set by the
// single compare and update between the input register and the scan state.
// Stall: while a summary waits on out_tready, samples of the next scan keep
// flowing in; only a second final sample holds in_tready low until the
// waiting summary is taken.
// Reset (rst_n low, synchronous): both stages empty, scan state cleared,
// under_limit = 0, over_limit = 0xFFFF. cfg_ port: under_limit 0x0, over_limit
// 0x4. The user writes limits only while no scan is in progress; unenforced.
module cell_window_fault_detector #(
  parameter int RECORD_SLOTS = cwfd_pkg::RECORD_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] monitor_index, [8:4] cell_index, [24:9] cell_code, [31:25] zero
  input  logic [cwfd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  // Output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] any_fault, [2:1] fault_mask, [10:3] first_location,
  // [18:11] second_location, [26:19] third_location, [34:27] fault_total,
  // [39:35] zero
  output logic [cwfd_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cwfd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cwfd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cwfd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  cwfd_pkg::cwfd_limits_t limits;
  cwfd_pkg::cwfd_sample_t sample;
  cwfd_pkg::cwfd_result_t result;
  logic                   sample_valid;
  logic                   advance;

  cwfd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .limits      (limits)
  );

  cwfd_window_cmp u_cmp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .monitor_index (in_tdata[3:0]),
    .cell_index    (in_tdata[8:4]),
    .cell_code     (in_tdata[24:9]),
    .scan_end      (in_tlast),
    .limits        (limits),
    .advance       (advance),
    .sample_valid  (sample_valid),
    .sample        (sample)
  );

  cwfd_accum #(
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample       (sample),
    .advance      (advance),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .result       (result)
  );

  // Pack the summary, any_fault lowest
  assign out_tdata = {{(cwfd_pkg::OUT_DATA_W-$bits(result)){1'b0}}, result};

endmodule
